// File: rtl/tbi_pkg.sv
// shared types and constants of the trigram bitset index builder
package tbi_pkg;

    localparam int GRAM_ROWS   = 1000;
    localparam int QUEUE_DEPTH = 4;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 11;
    localparam int DATA_W      = 64;

    localparam logic [7:0] CHAR_BASE = 8'h41;
    localparam logic [7:0] CHAR_LAST = 8'h4A;

    typedef enum logic [1:0] {
        ACT_CHAR,
        ACT_EOL,
        ACT_READ_GRAM,
        ACT_READ_DIGIT
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_COMMIT,
        STAT_SHORT,
        STAT_BAD_CHAR,
        STAT_FULL,
        STAT_BAD_READ
    } status_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_COMMIT,
        JOB_GRAM,
        JOB_DIGIT
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } job_ctl_t;

    typedef enum logic [1:0] {
        BE_CLEAR,
        BE_RUN,
        BE_GRAM
    } be_state_t;

endpackage

// File: rtl/tbi_front.sv
// front end: line assembly, classification and job generation
module tbi_front import tbi_pkg::*; #(
    parameter int STRING_SLOTS = 1024,
    parameter int LINE_DIGITS  = 15,
    parameter int WORD_BITS    = 64,
    localparam int ROW_WORDS   = (STRING_SLOTS + WORD_BITS - 1) / WORD_BITS,
    localparam int AB          = $clog2(GRAM_ROWS * ROW_WORDS),
    localparam int SW          = $clog2(STRING_SLOTS),
    localparam int CW          = $clog2(STRING_SLOTS + 1),
    localparam int WW          = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1,
    localparam int BW          = $clog2(WORD_BITS),
    localparam int DPW         = $clog2(LINE_DIGITS),
    localparam int PW          = $clog2(LINE_DIGITS + 1),
    localparam int LW          = LINE_DIGITS * 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     action,
    input  logic [7:0]     char_byte,
    input  logic [9:0]     gram_code,
    input  logic [3:0]     word_select,
    input  logic [9:0]     string_select,
    input  logic [3:0]     digit_position,
    input  logic           clear_done,
    input  logic           q_full,
    output logic           q_push,
    output job_ctl_t       q_ctl,
    output logic [AB-1:0]  q_addr,
    output logic [SW-1:0]  q_str,
    output logic [DPW-1:0] q_dsel,
    output logic [WW-1:0]  q_wrd,
    output logic [BW-1:0]  q_bit,
    output logic [LW-1:0]  q_digits
);

    action_t                 act;
    logic [PW-1:0]           pos_reg, pos_next;
    logic                    rej_reg, rej_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [WW-1:0]           wrd_reg, wrd_next;
    logic [BW-1:0]           bit_reg, bit_next;
    logic [LW-1:0]           digits_reg, digits_next;
    logic                    full;
    logic                    is_letter;
    logic [3:0]              digit;
    logic                    wsel_ok, dpos_ok, ssel_ok;
    logic [CW+COUNT_W-1:0]   count_ext;
    logic [SW+9:0]           sel_ext;
    logic [DPW+3:0]          dp_ext;

    assign act       = action_t'(action);
    assign s_tready  = clear_done & ~q_full;
    assign q_push    = s_tvalid & s_tready;
    assign full      = count_reg >= CW'(STRING_SLOTS);
    assign is_letter = (char_byte >= CHAR_BASE) && (char_byte <= CHAR_LAST);
    assign digit     = 4'(char_byte - CHAR_BASE);
    assign wsel_ok   = {28'b0, word_select} < 32'(ROW_WORDS);
    assign dpos_ok   = {28'b0, digit_position} < 32'(LINE_DIGITS);
    assign ssel_ok   = {{CW{1'b0}}, string_select} < {10'b0, count_reg};
    assign count_ext = {{COUNT_W{1'b0}}, count_next};
    assign sel_ext   = {{SW{1'b0}}, string_select};
    assign dp_ext    = {{DPW{1'b0}}, digit_position};

    assign q_addr   = AB'(gram_code) * AB'(ROW_WORDS) + AB'(word_select);
    assign q_str    = (act == ACT_READ_DIGIT) ? sel_ext[SW-1:0] : count_reg[SW-1:0];
    assign q_dsel   = dp_ext[DPW-1:0];
    assign q_wrd    = wrd_reg;
    assign q_bit    = bit_reg;
    assign q_digits = digits_reg;

    always_comb begin
        pos_next      = pos_reg;
        rej_next      = rej_reg;
        count_next    = count_reg;
        wrd_next      = wrd_reg;
        bit_next      = bit_reg;
        digits_next   = digits_reg;
        q_ctl.kind    = JOB_NONE;
        q_ctl.status  = STAT_OK;
        unique case (act)
            ACT_CHAR: begin
                if (full) begin
                    q_ctl.status = STAT_FULL;
                end else if (pos_reg < PW'(LINE_DIGITS)) begin
                    if (is_letter) begin
                        for (int i = 0; i < LINE_DIGITS; i++) begin
                            if (pos_reg == PW'(i)) begin
                                digits_next[i*4 +: 4] = digit;
                            end
                        end
                    end else begin
                        rej_next     = 1'b1;
                        q_ctl.status = STAT_BAD_CHAR;
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end
            ACT_EOL: begin
                if (full) begin
                    q_ctl.status = STAT_FULL;
                end else if (rej_reg) begin
                    q_ctl.status = STAT_BAD_CHAR;
                end else if (pos_reg < PW'(LINE_DIGITS)) begin
                    q_ctl.status = STAT_SHORT;
                end else begin
                    q_ctl.kind   = JOB_COMMIT;
                    q_ctl.status = STAT_COMMIT;
                    count_next   = count_reg + 1'b1;
                    if (bit_reg == BW'(WORD_BITS - 1)) begin
                        bit_next = '0;
                        wrd_next = wrd_reg + 1'b1;
                    end else begin
                        bit_next = bit_reg + 1'b1;
                    end
                end
                pos_next = '0;
                rej_next = 1'b0;
            end
            ACT_READ_GRAM: begin
                if ((gram_code < 10'(GRAM_ROWS)) && wsel_ok) begin
                    q_ctl.kind = JOB_GRAM;
                end else begin
                    q_ctl.status = STAT_BAD_READ;
                end
            end
            ACT_READ_DIGIT: begin
                if (ssel_ok && dpos_ok) begin
                    q_ctl.kind = JOB_DIGIT;
                end else begin
                    q_ctl.status = STAT_BAD_READ;
                end
            end
        endcase
        q_ctl.count = count_ext[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            rej_reg   <= 1'b0;
            count_reg <= '0;
            wrd_reg   <= '0;
            bit_reg   <= '0;
        end else if (q_push) begin
            pos_reg   <= pos_next;
            rej_reg   <= rej_next;
            count_reg <= count_next;
            wrd_reg   <= wrd_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            digits_reg <= digits_next;
        end
    end

endmodule

// File: rtl/tbi_queue.sv
// job queue between front end and back end
module tbi_queue import tbi_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             valid
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [QA-1:0]    wr_reg, rd_reg;
    logic [QC-1:0]    fill_reg;

    assign full  = fill_reg == QC'(QUEUE_DEPTH);
    assign valid = fill_reg != '0;
    assign rdata = entry_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/tbi_back.sv
// back end: bitset and digit memories, trigram update sequencer, result register
module tbi_back import tbi_pkg::*; #(
    parameter int STRING_SLOTS = 1024,
    parameter int LINE_DIGITS  = 15,
    parameter int WORD_BITS    = 64,
    localparam int ROW_WORDS   = (STRING_SLOTS + WORD_BITS - 1) / WORD_BITS,
    localparam int BS_DEPTH    = GRAM_ROWS * ROW_WORDS,
    localparam int AB          = $clog2(BS_DEPTH),
    localparam int SW          = $clog2(STRING_SLOTS),
    localparam int WW          = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1,
    localparam int BW          = $clog2(WORD_BITS),
    localparam int DPW         = $clog2(LINE_DIGITS),
    localparam int GW          = $clog2(LINE_DIGITS - 1),
    localparam int LW          = LINE_DIGITS * 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  job_ctl_t            q_ctl,
    input  logic [AB-1:0]       q_addr,
    input  logic [SW-1:0]       q_str,
    input  logic [DPW-1:0]      q_dsel,
    input  logic [WW-1:0]       q_wrd,
    input  logic [BW-1:0]       q_bit,
    input  logic [LW-1:0]       q_digits,
    output logic                q_pop,
    output logic                clear_done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] out_status,
    output logic [COUNT_W-1:0]  out_count,
    output logic [DATA_W-1:0]   out_data
);

    be_state_t               state_reg, state_next;
    logic [AB-1:0]           clr_reg, clr_next;
    logic                    gen_reg, gen_next;
    logic                    v1_reg, v1_next;
    logic                    v2_reg, v2_next;
    logic [GW-1:0]           gcnt_reg, gcnt_next;
    logic [LW-1:0]           sh_reg, sh_next;
    logic [WW-1:0]           wrd_reg, wrd_next;
    logic [WORD_BITS-1:0]    mask_reg, mask_next;
    logic [9:0]              code_reg, code_next;
    logic [AB-1:0]           wa_reg, gaddr;

    logic                    s1_v_reg;
    job_ctl_t                s1_ctl_reg;
    logic [DPW-1:0]          s1_dsel_reg;
    logic                    s1_adv;
    logic [DATA_W-1:0]       s1_data;
    logic [3:0]              s1_digit;
    logic [DATA_W+WORD_BITS-1:0] word_ext;

    logic                    o_v_reg;
    logic [STATUS_W-1:0]     o_status_reg;
    logic [COUNT_W-1:0]      o_count_reg;
    logic [DATA_W-1:0]       o_data_reg;

    logic [WORD_BITS-1:0]    bs_mem [BS_DEPTH];
    logic [WORD_BITS-1:0]    bs_rd_reg;
    logic                    bs_we, bs_re;
    logic [AB-1:0]           bs_wa, bs_ra;
    logic [WORD_BITS-1:0]    bs_wd;

    logic [LW-1:0]           dg_mem [STRING_SLOTS];
    logic [LW-1:0]           dg_rd_reg;
    logic                    dg_we, dg_re;

    assign clear_done = state_reg != BE_CLEAR;
    assign s1_adv     = s1_v_reg && (!o_v_reg || m_tready);
    assign gaddr      = AB'(code_reg) * AB'(ROW_WORDS) + AB'(wrd_reg);

    // sequencer: clearing pass, job dispatch, trigram read-modify-write pipeline
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        gen_next   = gen_reg;
        v1_next    = 1'b0;
        v2_next    = 1'b0;
        gcnt_next  = gcnt_reg;
        sh_next    = sh_reg;
        wrd_next   = wrd_reg;
        mask_next  = mask_reg;
        code_next  = code_reg;
        q_pop      = 1'b0;
        bs_we      = 1'b0;
        bs_wa      = '0;
        bs_wd      = '0;
        bs_re      = 1'b0;
        bs_ra      = '0;
        dg_we      = 1'b0;
        dg_re      = 1'b0;
        unique case (state_reg)
            BE_CLEAR: begin
                bs_we    = 1'b1;
                bs_wa    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AB'(BS_DEPTH - 1)) begin
                    state_next = BE_RUN;
                end
            end
            BE_RUN: begin
                if (q_valid && (!s1_v_reg || s1_adv)) begin
                    q_pop = 1'b1;
                    unique case (q_ctl.kind)
                        JOB_NONE: begin
                        end
                        JOB_GRAM: begin
                            bs_re = 1'b1;
                            bs_ra = q_addr;
                        end
                        JOB_DIGIT: begin
                            dg_re = 1'b1;
                        end
                        JOB_COMMIT: begin
                            dg_we      = 1'b1;
                            gen_next   = 1'b1;
                            gcnt_next  = '0;
                            sh_next    = q_digits;
                            wrd_next   = q_wrd;
                            mask_next  = {{(WORD_BITS-1){1'b0}}, 1'b1} << q_bit;
                            state_next = BE_GRAM;
                        end
                    endcase
                end
            end
            BE_GRAM: begin
                if (gen_reg) begin
                    v1_next   = 1'b1;
                    code_next = 10'(sh_reg[3:0]) * 10'd100 + 10'(sh_reg[7:4]) * 10'd10
                              + 10'(sh_reg[11:8]);
                    sh_next   = sh_reg >> 4;
                    gcnt_next = gcnt_reg + 1'b1;
                    if (gcnt_reg == GW'(LINE_DIGITS - 3)) begin
                        gen_next = 1'b0;
                    end
                end
                if (v1_reg) begin
                    bs_re   = 1'b1;
                    bs_ra   = gaddr;
                    v2_next = 1'b1;
                end
                if (v2_reg) begin
                    bs_we = 1'b1;
                    bs_wa = wa_reg;
                    bs_wd = bs_rd_reg | mask_reg;
                end
                if (!gen_reg && !v1_reg && !v2_reg) begin
                    state_next = BE_RUN;
                end
            end
            default: begin
                state_next = BE_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BE_CLEAR;
            clr_reg   <= '0;
            gen_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            s1_v_reg  <= 1'b0;
            o_v_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            gen_reg   <= gen_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            if (q_pop) begin
                s1_v_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_v_reg <= 1'b0;
            end
            if (s1_adv) begin
                o_v_reg <= 1'b1;
            end else if (m_tready) begin
                o_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        gcnt_reg  <= gcnt_next;
        sh_reg    <= sh_next;
        wrd_reg   <= wrd_next;
        mask_reg  <= mask_next;
        code_reg  <= code_next;
        wa_reg    <= gaddr;
        if (q_pop) begin
            s1_ctl_reg  <= q_ctl;
            s1_dsel_reg <= q_dsel;
        end
        if (s1_adv) begin
            o_status_reg <= s1_ctl_reg.status;
            o_count_reg  <= s1_ctl_reg.count;
            o_data_reg   <= s1_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (bs_we) begin
            bs_mem[bs_wa] <= bs_wd;
        end
        if (bs_re) begin
            bs_rd_reg <= bs_mem[bs_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (dg_we) begin
            dg_mem[q_str] <= q_digits;
        end
        if (dg_re) begin
            dg_rd_reg <= dg_mem[q_str];
        end
    end

    assign word_ext = {{DATA_W{1'b0}}, bs_rd_reg};

    always_comb begin
        s1_digit = '0;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (s1_dsel_reg == DPW'(i)) begin
                s1_digit = dg_rd_reg[i*4 +: 4];
            end
        end
        case (s1_ctl_reg.kind)
            JOB_GRAM:  s1_data = word_ext[DATA_W-1:0];
            JOB_DIGIT: s1_data = {{(DATA_W-4){1'b0}}, s1_digit};
            default:   s1_data = '0;
        endcase
    end

    assign m_tvalid   = o_v_reg;
    assign out_status = o_status_reg;
    assign out_count  = o_count_reg;
    assign out_data   = o_data_reg;

    // no job leaves the queue before the bitset is cleared
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_CLEAR |-> !q_pop)
        else $error("job dispatched during clearing pass");

    // write stage only follows a read stage
    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> $past(v1_reg))
        else $error("bitset write without preceding read");

    // a pending bitset read result never shares the read port with an update
    a_port_share: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg || v2_reg) |-> !(s1_v_reg && s1_ctl_reg.kind == JOB_GRAM))
        else $error("bitset read result clobbered by trigram update");

    // the update sequence starts only from a commit job
    a_gram_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BE_GRAM && $past(state_reg) == BE_RUN)
            |-> $past(q_pop && q_ctl.kind == JOB_COMMIT))
        else $error("trigram update started without commit");

endmodule

// File: rtl/trigram_bitset_index_builder_unit.sv
// top level of the trigram bitset index builder
// path: a result passes through the job queue, the dispatch stage and the output register; more under stall
// throughput: one transaction per cycle while s_tready is high; a committed string holds the
//   bitset port for LINE_DIGITS-2 trigram read-modify-writes, absorbed by a 4-entry queue
// reset: synchronous, active low; a clearing pass zeroes all GRAM_ROWS*ceil(STRING_SLOTS/WORD_BITS)
//   bitset words (16000 by default) while s_tready stays low
module trigram_bitset_index_builder_unit import tbi_pkg::*; #(
    parameter int STRING_SLOTS = 1024,
    parameter int LINE_DIGITS  = 15,
    parameter int WORD_BITS    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // char_byte, gram_code, word_select, string_select, digit_position
    input  logic [1:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // status, string_count, read_data
);

    localparam int ROW_WORDS = (STRING_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AB        = $clog2(GRAM_ROWS * ROW_WORDS);
    localparam int SW        = $clog2(STRING_SLOTS);
    localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int DPW       = $clog2(LINE_DIGITS);
    localparam int LW        = LINE_DIGITS * 4;
    localparam int JW        = $bits(job_ctl_t) + AB + SW + DPW + WW + BW + LW;

    logic                 clear_done;
    logic                 q_full, q_push, q_pop, q_valid;
    job_ctl_t             f_ctl, b_ctl;
    logic [AB-1:0]        f_addr, b_addr;
    logic [SW-1:0]        f_str, b_str;
    logic [DPW-1:0]       f_dsel, b_dsel;
    logic [WW-1:0]        f_wrd, b_wrd;
    logic [BW-1:0]        f_bit, b_bit;
    logic [LW-1:0]        f_digits, b_digits;
    logic [JW-1:0]        q_wdata, q_rdata;
    logic [STATUS_W-1:0]  out_status;
    logic [COUNT_W-1:0]   out_count;
    logic [DATA_W-1:0]    out_data;

    tbi_front #(
        .STRING_SLOTS (STRING_SLOTS),
        .LINE_DIGITS  (LINE_DIGITS),
        .WORD_BITS    (WORD_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .action         (s_tuser),
        .char_byte      (s_tdata[7:0]),
        .gram_code      (s_tdata[17:8]),
        .word_select    (s_tdata[21:18]),
        .string_select  (s_tdata[31:22]),
        .digit_position (s_tdata[35:32]),
        .clear_done     (clear_done),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_ctl          (f_ctl),
        .q_addr         (f_addr),
        .q_str          (f_str),
        .q_dsel         (f_dsel),
        .q_wrd          (f_wrd),
        .q_bit          (f_bit),
        .q_digits       (f_digits)
    );

    assign q_wdata = {f_digits, f_bit, f_wrd, f_dsel, f_str, f_addr, f_ctl};

    tbi_queue #(
        .WIDTH (JW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .valid   (q_valid)
    );

    assign {b_digits, b_bit, b_wrd, b_dsel, b_str, b_addr, b_ctl} = q_rdata;

    tbi_back #(
        .STRING_SLOTS (STRING_SLOTS),
        .LINE_DIGITS  (LINE_DIGITS),
        .WORD_BITS    (WORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ctl      (b_ctl),
        .q_addr     (b_addr),
        .q_str      (b_str),
        .q_dsel     (b_dsel),
        .q_wrd      (b_wrd),
        .q_bit      (b_bit),
        .q_digits   (b_digits),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_count  (out_count),
        .out_data   (out_data)
    );

    assign m_tdata = {2'b00, out_data, out_count, out_status};

endmodule
